### rtl/core/sha256_message_padder_macros.svh
// Assertion macros shared by the SHA-256 message padder checkers.
// Each macro clocks on the given clock and is disabled while reset is low.
`ifndef SHA256_MESSAGE_PADDER_MACROS_SVH
`define SHA256_MESSAGE_PADDER_MACROS_SVH

// Same-cycle implication: whenever a holds, b holds too.
`define SMP_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("smp check failed: same-cycle implication");

// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define SMP_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("smp check failed: next-cycle implication");

`endif

### rtl/core/smp_pkg.sv
// Shared types and constants for the SHA-256 message padder.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package smp_pkg;

  // Input request kinds carried on the slave tuser
  localparam logic [1:0] ACT_DATA = 2'd0;  // message byte
  localparam logic [1:0] ACT_LAST = 2'd1;  // message byte that ends the message
  localparam logic [1:0] ACT_END  = 2'd2;  // end the message without a byte

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 61;

  localparam logic [7:0]       PAD_BYTE  = 8'h80;
  localparam logic [POS_W-1:0] LEN_START = 6'd56;
  localparam logic [IDX_W-1:0] IDX_HI    = 4'd14;
  localparam logic [IDX_W-1:0] IDX_LAST  = 4'd15;

  typedef enum logic {
    ST_RUN,
    ST_PAD
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_byte;
    logic start_pad;
    logic emit_pad;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_free;
    logic pad_last;
  } dp_status_t;

endpackage

### rtl/core/sha256_message_padder.sv
// SHA-256 message padder: one byte per cycle in while not stalled, big-endian words out.
// A word appears in the cycle after the request with its fourth byte.
// Throughput: one byte request per cycle while not stalled; an ending request
// then emits 3 to 18 padding words, one per cycle while not stalled, through
// the single output register, and holds off new requests until the last padding word is loaded.
// Reset: asynchronous active low, clears the packer, count and all valids.
`timescale 1ns / 1ps

module sha256_message_padder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] word
  output logic [4:0]  m_axis_tuser,   // [3:0] word_index, [4] block_end
  output logic        m_axis_tlast    // message_end
);

  smp_pkg::ctrl_cmd_t  cmd;
  smp_pkg::dp_status_t status;
  logic [3:0]          out_idx;
  logic                out_bend;

  smp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_action_i (s_axis_tuser),
    .req_ready_o  (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  smp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .byte_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_idx_o   (out_idx),
    .out_bend_o  (out_bend),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = {out_bend, out_idx};

endmodule

### rtl/core/smp_ctrl.sv
// Controller state machine of the SHA-256 message padder.
// Depends on smp_pkg; drives commands to smp_datapath.
`timescale 1ns / 1ps

module smp_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic [smp_pkg::ACT_W-1:0]      req_action_i,
  output logic                           req_ready_o,
  input  smp_pkg::dp_status_t            status_i,
  output smp_pkg::ctrl_cmd_t             cmd_o
);

  smp_pkg::state_e state_q, state_d;
  logic            accept;

  assign accept = req_valid_i && req_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smp_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      smp_pkg::ST_RUN: begin
        if (accept && (req_action_i == smp_pkg::ACT_LAST ||
                       req_action_i == smp_pkg::ACT_END)) begin
          state_d = smp_pkg::ST_PAD;
        end
      end
      smp_pkg::ST_PAD: begin
        if (status_i.slot_free && status_i.pad_last) begin
          state_d = smp_pkg::ST_RUN;
        end
      end
      default: state_d = smp_pkg::ST_RUN;
    endcase
  end

  // Outputs: take requests while running, emit padding words while padding
  always_comb begin
    req_ready_o     = 1'b0;
    cmd_o.take_byte = 1'b0;
    cmd_o.start_pad = 1'b0;
    cmd_o.emit_pad  = 1'b0;
    case (state_q)
      smp_pkg::ST_RUN: begin
        req_ready_o     = status_i.slot_free;
        cmd_o.take_byte = accept && (req_action_i == smp_pkg::ACT_DATA ||
                                     req_action_i == smp_pkg::ACT_LAST);
        cmd_o.start_pad = accept && (req_action_i == smp_pkg::ACT_LAST ||
                                     req_action_i == smp_pkg::ACT_END);
      end
      smp_pkg::ST_PAD: begin
        cmd_o.emit_pad = status_i.slot_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/smp_datapath.sv
// Datapath of the SHA-256 message padder: word packing, byte count,
// padding word generation and the output register. Depends on smp_pkg.
`timescale 1ns / 1ps

module smp_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  smp_pkg::ctrl_cmd_t             cmd_i,
  output smp_pkg::dp_status_t            status_o,
  input  logic [smp_pkg::BYTE_W-1:0]     byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [smp_pkg::WORD_W-1:0]     out_word_o,
  output logic [smp_pkg::IDX_W-1:0]      out_idx_o,
  output logic                           out_bend_o,
  output logic                           out_last_o
);

  logic [23:0]                  partial_q, partial_d;
  logic [smp_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [smp_pkg::CNT_W-1:0]    count_q, count_d;
  logic [smp_pkg::IDX_W-1:0]    pad_idx_q, pad_idx_d;
  logic                         pad_first_q, pad_first_d;
  logic                         pad_two_q, pad_two_d;
  logic                         out_valid_q, out_valid_d;
  logic [smp_pkg::WORD_W-1:0]   out_word_q, out_word_d;
  logic [smp_pkg::IDX_W-1:0]    out_idx_q, out_idx_d;
  logic                         out_bend_q, out_bend_d;
  logic                         out_last_q, out_last_d;
  logic                         slot_free;
  logic                         pad_last;
  logic [smp_pkg::WORD_W-1:0]   pad_first_word;
  logic [smp_pkg::WORD_W-1:0]   pad_word;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pad_last  = !pad_two_q && (pad_idx_q == smp_pkg::IDX_LAST);

  assign status_o.slot_free = slot_free;
  assign status_o.pad_last  = pad_last;

  // Partial word followed by the 0x80 marker, placed after the bytes present
  always_comb begin
    case (pos_q[1:0])
      2'd0:    pad_first_word = {smp_pkg::PAD_BYTE, 24'h0};
      2'd1:    pad_first_word = {partial_q[7:0], smp_pkg::PAD_BYTE, 16'h0};
      2'd2:    pad_first_word = {partial_q[15:0], smp_pkg::PAD_BYTE, 8'h0};
      2'd3:    pad_first_word = {partial_q[23:0], smp_pkg::PAD_BYTE};
      default: pad_first_word = '0;
    endcase
  end

  // Select the current padding word: marker, zero fill or bit length
  always_comb begin
    pad_word = '0;
    if (pad_first_q) begin
      pad_word = pad_first_word;
    end else if (!pad_two_q && pad_idx_q == smp_pkg::IDX_HI) begin
      pad_word = count_q[60:29];
    end else if (!pad_two_q && pad_idx_q == smp_pkg::IDX_LAST) begin
      pad_word = {count_q[28:0], 3'b000};
    end
  end

  // Next state of the packer, the padding sequencer and the output register
  always_comb begin
    partial_d   = partial_q;
    pos_d       = pos_q;
    count_d     = count_q;
    pad_idx_d   = pad_idx_q;
    pad_first_d = pad_first_q;
    pad_two_d   = pad_two_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_bend_d  = out_bend_q;
    out_last_d  = out_last_q;

    // drop the held word once the sink takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // pack a byte, emit the word on every fourth byte
    if (cmd_i.take_byte) begin
      if (pos_q[1:0] == 2'd3) begin
        out_valid_d = 1'b1;
        out_word_d  = {partial_q, byte_i};
        out_idx_d   = pos_q[5:2];
        out_bend_d  = (pos_q == 6'd63);
        out_last_d  = 1'b0;
        partial_d   = '0;
      end else begin
        partial_d = {partial_q[15:0], byte_i};
      end
      pos_d   = pos_q + 6'd1;
      count_d = count_q + 61'd1;
    end

    // arm the padding sequencer from the updated block position
    if (cmd_i.start_pad) begin
      pad_idx_d   = pos_d[5:2];
      pad_first_d = 1'b1;
      pad_two_d   = (pos_d >= smp_pkg::LEN_START);
    end

    // emit one padding word and advance
    if (cmd_i.emit_pad) begin
      out_valid_d = 1'b1;
      out_word_d  = pad_word;
      out_idx_d   = pad_idx_q;
      out_bend_d  = (pad_idx_q == smp_pkg::IDX_LAST);
      out_last_d  = pad_last;
      pad_idx_d   = pad_idx_q + 4'd1;
      pad_first_d = 1'b0;
      if (pad_idx_q == smp_pkg::IDX_LAST) begin
        pad_two_d = 1'b0;
      end
      if (pad_last) begin
        partial_d = '0;
        pos_d     = '0;
        count_d   = '0;
      end
    end
  end

  // Control state and message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pad_first_q <= 1'b0;
      pad_two_q   <= 1'b0;
      pad_idx_q   <= '0;
    end else begin
      partial_q   <= partial_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      pad_first_q <= pad_first_d;
      pad_two_q   <= pad_two_d;
      pad_idx_q   <= pad_idx_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_bend_q <= out_bend_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_idx_o   = out_idx_q;
  assign out_bend_o  = out_bend_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/core/smp_checker.sv
// Port-level checks for the SHA-256 message padder, bound to the top level.
// Depends on sha256_message_padder_macros.svh.
`timescale 1ns / 1ps
`include "sha256_message_padder_macros.svh"

module smp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic end_req;
  logic out_stall;
  logic bend_ok;

  assign end_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == smp_pkg::ACT_END);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign bend_ok = m_axis_tuser[4] == (m_axis_tuser[3:0] == 4'hf);

  // a stalled result holds its word
  `SMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // block end flags exactly the last word slot of a block
  `SMP_ASSERT_IMP(a_bend_idx, clk_i, rst_ni, m_axis_tvalid, bend_ok)

  // message end only on a closing word
  `SMP_ASSERT_IMP(a_last_bend, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[4])

  // an end request blocks new requests while padding runs
  `SMP_ASSERT_NXT(a_end_stall, clk_i, rst_ni, end_req, !s_axis_tready)

endmodule

bind sha256_message_padder smp_checker u_smp_checker (.*);

### tb/sha256_message_padder_test.sv
// Self-checking testbench for the SHA-256 message padder stream block.
// Drives byte requests, predicts every padded word in place and checks the
// output stream field by field; depends only on smp_pkg and the padder RTL.
`timescale 1ns / 1ps

module sha256_message_padder_test;

  // Request kind the block must ignore
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        block_end;
    logic        msg_end;
  } padded_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = smp_pkg::ACT_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state: bytes of the open word, position in block, byte count
  logic [23:0] open_bytes;
  logic [5:0]  block_bytes;
  logic [60:0] msg_bytes;

  padded_word_t expected_words[$];
  int           fail_count;
  int           sent_items;
  int           cycle_count;
  int           stall_left;
  logic         send_idle_on;
  logic         recv_idle_on;

  sha256_message_padder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Queue one expected padded word
  task automatic push_word(logic [31:0] w, logic [3:0] idx, logic bend, logic mend);
    padded_word_t pw;
    pw.word      = w;
    pw.index     = idx;
    pw.block_end = bend;
    pw.msg_end   = mend;
    expected_words.push_back(pw);
  endtask

  // Place one message byte; every fourth byte completes a word
  task automatic absorb_byte(logic [7:0] b);
    if (block_bytes[1:0] == 2'd3) begin
      push_word({open_bytes, b}, block_bytes[5:2], block_bytes == 6'd63, 1'b0);
      open_bytes = '0;
    end else begin
      open_bytes = {open_bytes[15:0], b};
    end
    block_bytes = block_bytes + 6'd1;
    msg_bytes   = msg_bytes + 61'd1;
  endtask

  // Append the pad byte, zero fill and the 64-bit bit length
  task automatic close_message();
    int          k;
    int          r;
    logic [63:0] bit_len;
    logic [63:0] head;
    k       = int'(block_bytes[5:2]);
    r       = int'(block_bytes[1:0]);
    bit_len = {msg_bytes, 3'b000};
    head    = ({40'd0, open_bytes} << (8 * (4 - r))) |
              ({56'd0, smp_pkg::PAD_BYTE} << (8 * (3 - r)));
    if (block_bytes < smp_pkg::LEN_START) begin
      push_word(head[31:0], 4'(k), 1'b0, 1'b0);
      for (int i = k + 1; i < int'(smp_pkg::IDX_HI); i++)
        push_word('0, 4'(i), 1'b0, 1'b0);
    end else begin
      push_word(head[31:0], 4'(k), k == int'(smp_pkg::IDX_LAST), 1'b0);
      for (int i = k + 1; i <= int'(smp_pkg::IDX_LAST); i++)
        push_word('0, 4'(i), i == int'(smp_pkg::IDX_LAST), 1'b0);
      for (int i = 0; i < int'(smp_pkg::IDX_HI); i++) push_word('0, 4'(i), 1'b0, 1'b0);
    end
    push_word(bit_len[63:32], smp_pkg::IDX_HI, 1'b0, 1'b0);
    push_word(bit_len[31:0], smp_pkg::IDX_LAST, 1'b1, 1'b1);
    open_bytes  = '0;
    block_bytes = '0;
    msg_bytes   = '0;
  endtask

  // Work out the words caused by one accepted request
  task automatic predict_padding(logic [1:0] act, logic [7:0] b);
    case (act)
      smp_pkg::ACT_DATA: begin
        absorb_byte(b);
      end
      smp_pkg::ACT_LAST: begin
        absorb_byte(b);
        close_message();
      end
      smp_pkg::ACT_END: begin
        close_message();
      end
      default: ;
    endcase
  endtask

  // Send one request, with an optional idle burst in front of it
  task automatic send_request(logic [1:0] act, logic [7:0] b);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_padding(act, b);
    if (act != ACT_UNUSED) sent_items++;
  endtask

  // Send a message of len bytes, ended by the last byte or by a bare end
  task automatic send_message(int len, logic end_on_byte);
    int body;
    body = (end_on_byte && len > 0) ? len - 1 : len;
    for (int i = 0; i < body; i++) begin
      if ($urandom_range(0, 15) == 0) send_request(ACT_UNUSED, 8'($urandom));
      send_request(smp_pkg::ACT_DATA, 8'($urandom));
    end
    if (end_on_byte && len > 0) send_request(smp_pkg::ACT_LAST, 8'($urandom));
    else send_request(smp_pkg::ACT_END, 8'($urandom));
  endtask

  // Mostly short messages, some around the one/two block boundary
  function automatic int pick_length();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom_range(0, 9);
      2:       return $urandom_range(52, 68);
      default: return $urandom_range(10, 51);
    endcase
  endfunction

  task automatic test_empty_message();
    send_request(ACT_UNUSED, 8'hFF);
    send_request(smp_pkg::ACT_END, 8'h00);
    send_request(smp_pkg::ACT_END, 8'hFF);
  endtask

  task automatic test_single_byte_messages();
    send_request(smp_pkg::ACT_LAST, 8'hFF);
    send_request(smp_pkg::ACT_LAST, 8'h00);
  endtask

  task automatic test_partial_words();
    // Four bytes: ends on a word boundary
    send_request(smp_pkg::ACT_DATA, 8'h01);
    send_request(smp_pkg::ACT_DATA, 8'h23);
    send_request(smp_pkg::ACT_DATA, 8'h45);
    send_request(smp_pkg::ACT_LAST, 8'h67);
    // Three bytes then a bare end
    send_request(smp_pkg::ACT_DATA, 8'hDE);
    send_request(smp_pkg::ACT_DATA, 8'hAD);
    send_request(smp_pkg::ACT_DATA, 8'hBE);
    send_request(smp_pkg::ACT_END, 8'hEF);
    // Ignored request in the middle of a message
    send_request(smp_pkg::ACT_DATA, 8'h5A);
    send_request(ACT_UNUSED, 8'h00);
    send_request(smp_pkg::ACT_DATA, 8'hA5);
    send_request(smp_pkg::ACT_END, 8'h00);
  endtask

  task automatic test_random_messages(int n_items);
    int stop_at;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      send_idle_on = $urandom_range(0, 2) != 0;
      recv_idle_on = $urandom_range(0, 2) != 0;
      send_message(pick_length(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_streaming_tail(int n_items);
    int stop_at;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) send_message(pick_length(), 1'($urandom_range(0, 1)));
  endtask

  // Output stalls come in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (rst_ni && recv_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    padded_word_t got;
    padded_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.word      = m_axis_tdata;
      got.index     = m_axis_tuser[3:0];
      got.block_end = m_axis_tuser[4];
      got.msg_end   = m_axis_tlast;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected word %h idx %0d bend %b mend %b", $realtime,
                   got.word, got.index, got.block_end, got.msg_end);
      end else begin
        want = expected_words.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b", $realtime,
                     want.word, want.index, want.block_end, want.msg_end,
                     got.word, got.index, got.block_end, got.msg_end);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    open_bytes   = '0;
    block_bytes  = '0;
    msg_bytes    = '0;
    fail_count   = 0;
    sent_items   = 0;
    cycle_count  = 0;
    stall_left   = 0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_message();
    test_single_byte_messages();
    test_partial_words();
    test_random_messages(170);
    test_streaming_tail(50);

    // Drop the request line and drain the remaining words
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
